[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, widths and codes for the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int FILL_W = 5;
  localparam int DATA_W = 32;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } entry_t;

  // Per-cycle control for one cell; ins and rem are broadcast to every cell
  typedef struct packed {
    logic ins;       // insert beat in progress (queue not full)
    logic rem;       // remove beat in progress (queue not empty)
    logic occupied;  // this cell holds a live entry
    logic left_cmp;  // left neighbor's "new entry goes at or before me" flag
  } cell_ctrl_t;

endpackage

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted array: holds one entry, compares it with the
// incoming priority and takes from its left or right neighbor or the input.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  entry_t     new_entry,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       cmp
);

  entry_t entry_next;

  // New entry belongs here or earlier; equal priorities stay ahead of it.
  assign cmp = !ctrl.occupied || (new_entry.prio < entry.prio);

  always_comb begin
    entry_next = entry;
    if (ctrl.ins && cmp) begin
      entry_next = ctrl.left_cmp ? left_entry : new_entry;
    end else if (ctrl.rem) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[src/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept as a sorted row of cells; every command
// (insert, remove smallest, clear) returns one result beat.
// ----------------------------------------------------------------------------
//
//   channel  | handshake            | payload
//   ---------+----------------------+--------------------------------------
//   in       | in_valid / in_ready  | command, in_value, in_priority
//   out      | out_valid / out_ready| out_value, out_priority, status,
//            |                      | fill_count
//
// Cycles: one command per cycle unless the output stalls. The row of cells
//   and the output register both load at the edge that accepts the input
//   beat, so the result beat is offered in the next cycle. The per-cell
//   compare against the broadcast priority and the shift by one place set
//   this figure, independent of DEPTH.
// Reset: clears the entry count and the output valid; cell contents are
//   left as they are and are never read before being written.
// Stalls: in_ready stays high while the output register is empty or being
//   drained, so a new beat enters as the pending result leaves.
// ----------------------------------------------------------------------------
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic signed [DATA_W-1:0] in_value,
  input  logic signed [DATA_W-1:0] in_priority,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] out_value,
  output logic signed [DATA_W-1:0] out_priority,
  output logic [1:0]               status,
  output logic [FILL_W-1:0]        fill_count
);

  // Live entries occupy cells 0 .. count-1, smallest priority in cell 0.
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  entry_t                   cells [DEPTH];
  logic       [DEPTH-1:0]   cmp;
  cell_ctrl_t               ctrl  [DEPTH];
  entry_t                   new_entry;

  logic fire;
  logic full;
  logic empty;
  logic do_ins;
  logic do_rem;

  logic signed [DATA_W-1:0] res_value;
  logic signed [DATA_W-1:0] res_priority;
  logic [1:0]               res_status;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign do_ins   = fire && (command == CMD_INSERT) && !full;
  assign do_rem   = fire && (command == CMD_REMOVE) && !empty;

  assign new_entry.value = in_value;
  assign new_entry.prio  = in_priority;

  // Build the row: each cell hands its entry to the right on insert and to
  // the left on remove. The last cell refills from itself on remove; it
  // drops out of the live range anyway.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign ctrl[i].ins      = do_ins;
    assign ctrl[i].rem      = do_rem;
    assign ctrl[i].occupied = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      assign ctrl[i].left_cmp = 1'b0;
    end else begin : g_rest
      assign ctrl[i].left_cmp = cmp[i-1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl[i]),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? cells[0] : cells[(i == 0) ? 0 : i-1]),
      .right_entry (cells[(i == DEPTH-1) ? i : i+1]),
      .entry       (cells[i]),
      .cmp         (cmp[i])
    );
  end

  // Decode the command into the result and the next fill count.
  always_comb begin
    count_next   = count;
    res_value    = '0;
    res_priority = '0;
    res_status   = ST_OK;
    unique case (command)
      CMD_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_value    = cells[0].value;
          res_priority = cells[0].prio;
          count_next   = count - CNT_W'(1);
        end
      end
      CMD_CLEAR: begin
        count_next = '0;
      end
      default: begin
        // unused code: leave the queue alone, report ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload: load on an accepted beat, hold while stalled.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_value    <= res_value;
      out_priority <= res_priority;
      status       <= res_status;
      fill_count   <= FILL_W'(count_next);
    end
  end

endmodule

[src/spq_checker.sv]
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks on the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker
  import spq_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic [1:0]               command,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [DATA_W-1:0] out_value,
  input logic signed [DATA_W-1:0] out_priority,
  input logic [1:0]               status,
  input logic [FILL_W-1:0]        fill_count
);

  // A stalled result beat stays valid and holds its status and fill count.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(fill_count))
    else $error("result beat changed while stalled");

  // A full rejection only happens with DEPTH entries held.
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> (fill_count == FILL_W'(DEPTH)))
    else $error("full status with fill count below depth");

  // An empty rejection reports zero entries and no payload.
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> (fill_count == '0) && (out_value == '0)
      && (out_priority == '0))
    else $error("empty status with entries or payload");

  // An accepted clear leaves the queue empty in its result.
  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (command == CMD_CLEAR) |=> out_valid && (fill_count == '0)
      && (status == ST_OK))
    else $error("clear did not empty the queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (.*);

[sim/tb_sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue
// Self-checking bench for the sorted priority queue: a directed opening
// (empty and tie cases, priority extremes, clear, unused command), then
// random command runs biased toward filling, balanced or draining. A sorted shadow
// queue predicts each result beat. Both channels see random idle and stall.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  // Command code 3 has no function; the block reports status and fill only
  localparam logic [1:0] CMD_NOP = 2'd3;

  localparam logic signed [DATA_W-1:0] PRIO_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] PRIO_MIN = 32'sh8000_0000;

  localparam int IDLE_LIMIT   = 2000;  // cycles without any beat before giving up
  localparam int DRAIN_CYCLES = 8;     // result is offered in the cycle after the input beat
  localparam int PHASE_ITEMS  = 64;
  localparam int RUN_LEN      = 24;    // items per fill/drain bias run

  typedef struct {
    logic [1:0]               command;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } cmd_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
    logic [1:0]               status;
    logic [FILL_W-1:0]        fill;
  } result_beat_t;

  typedef struct {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] prio;
  } held_entry_t;

  logic                     clk         = 1'b0;
  logic                     rst         = 1'b1;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [1:0]               command     = CMD_INSERT;
  logic signed [DATA_W-1:0] in_value    = '0;
  logic signed [DATA_W-1:0] in_priority = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic signed [DATA_W-1:0] out_priority;
  logic [1:0]               status;
  logic [FILL_W-1:0]        fill_count;

  cmd_beat_t    pending_cmds[$];      // commands waiting to go out
  result_beat_t expected_results[$];  // predicted result beats, oldest first
  held_entry_t  shadow_queue[$];      // predicted queue contents, smallest priority first
  cmd_beat_t    in_flight = '{CMD_INSERT, '0, '0};

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic in_taken       = 1'b0;
  int   fails          = 0;
  int   quiet_cycles   = 0;

  sorted_priority_queue dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .in_value    (in_value),
    .in_priority (in_priority),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .out_priority(out_priority),
    .status      (status),
    .fill_count  (fill_count)
  );

  initial forever #1 clk = ~clk;

  // Apply one command to the shadow queue and return the result it causes.
  function automatic result_beat_t apply_command(cmd_beat_t c);
    result_beat_t r;
    held_entry_t  e;
    int           pos;
    r.value  = '0;
    r.prio   = '0;
    r.status = ST_OK;
    case (c.command)
      CMD_INSERT: begin
        if (shadow_queue.size() >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // walk back past strictly larger priorities only, so ties keep arrival order
          pos = shadow_queue.size();
          while (pos > 0 && c.prio < shadow_queue[pos-1].prio) pos--;
          e.value = c.value;
          e.prio  = c.prio;
          shadow_queue.insert(pos, e);
        end
      end
      CMD_REMOVE: begin
        if (shadow_queue.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = shadow_queue[0].value;
          r.prio  = shadow_queue[0].prio;
          void'(shadow_queue.pop_front());
        end
      end
      CMD_CLEAR: begin
        shadow_queue.delete();
      end
      default: ;  // unused code: state untouched
    endcase
    r.fill = FILL_W'(shadow_queue.size());
    return r;
  endfunction

  // Draw one random command. fill_bias is the insert share in percent; many
  // priorities come from a small set so ties are common, with the extremes mixed in.
  function automatic cmd_beat_t random_command(int fill_bias);
    cmd_beat_t c;
    int        roll;
    roll = $urandom_range(99);
    if (roll < 3)                  c.command = CMD_CLEAR;
    else if (roll < 6)             c.command = CMD_NOP;
    else if (roll < 6 + fill_bias) c.command = CMD_INSERT;
    else                           c.command = CMD_REMOVE;
    c.value = $urandom;
    roll = $urandom_range(99);
    if (roll < 40)      c.prio = (int'($urandom_range(7)) - 4) * 65536;
    else if (roll < 50) c.prio = $urandom_range(1) ? PRIO_MAX : PRIO_MIN;
    else                c.prio = $urandom;
    return c;
  endfunction

  function automatic void push_directed(logic [1:0] cmd, logic signed [DATA_W-1:0] v,
                                        logic signed [DATA_W-1:0] p);
    cmd_beat_t c;
    c.command = cmd;
    c.value   = v;
    c.prio    = p;
    pending_cmds.push_back(c);
  endfunction

  // Queue random items under one idle/stall setting, then hold the sender
  // until every predicted result has come back.
  task automatic run_phase(int idle_pct, int stall_pct, int n_items);
    int fill_bias;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    fill_bias      = 50;
    for (int i = 0; i < n_items; i++) begin
      if (i % RUN_LEN == 0) begin
        case ($urandom_range(2))
          0:       fill_bias = 80;
          1:       fill_bias = 47;
          default: fill_bias = 14;
        endcase
      end
      pending_cmds.push_back(random_command(fill_bias));
    end
    while (pending_cmds.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Flag the cycle after an input beat; prediction runs at the next falling edge.
  // Also run the watchdog on beats from either channel.
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Driver: predict the beat just taken, then hold the current beat or
  // present the next one, idling at random.
  always @(negedge clk) begin
    logic send_next;
    send_next = in_valid && !in_taken;
    if (in_taken) expected_results.push_back(apply_command(in_flight));
    if (!send_next && pending_cmds.size() != 0 &&
        $urandom_range(99) >= send_idle_pct) begin
      in_flight = pending_cmds.pop_front();
      send_next = 1'b1;
    end
    in_valid    <= send_next;
    command     <= in_flight.command;
    in_value    <= in_flight.value;
    in_priority <= in_flight.prio;
  end

  // Receiver: drop ready at random.
  always @(negedge clk) begin
    out_ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    result_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with no prediction pending");
        fails++;
      end else begin
        want = expected_results.pop_front();
        if (out_value !== want.value) begin
          $error("out_value: expected %0d, got %0d", want.value, out_value);
          fails++;
        end
        if (out_priority !== want.prio) begin
          $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
          fails++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fails++;
        end
        if (fill_count !== want.fill) begin
          $error("fill_count: expected %0d, got %0d", want.fill, fill_count);
          fails++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening: empty-queue rejects, unused code, priority and value
    // extremes, equal priorities leaving in arrival order, clear.
    push_directed(CMD_REMOVE, 32'sd0, 32'sd0);
    push_directed(CMD_NOP,    32'sd5, 32'sd5);
    push_directed(CMD_INSERT, PRIO_MAX, PRIO_MAX);
    push_directed(CMD_INSERT, PRIO_MIN, PRIO_MIN);
    push_directed(CMD_INSERT, 32'sd1, 32'sd0);
    push_directed(CMD_INSERT, 32'sd2, 32'sd0);
    push_directed(CMD_INSERT, 32'sd3, PRIO_MAX);
    push_directed(CMD_INSERT, -32'sd1, -32'sd1);
    push_directed(CMD_NOP,    32'sd0, 32'sd0);
    repeat (6) push_directed(CMD_REMOVE, 32'sd0, 32'sd0);
    push_directed(CMD_REMOVE, 32'sd0, 32'sd0);
    push_directed(CMD_INSERT, 32'sd0, 32'sh0001_0000);
    push_directed(CMD_INSERT, -32'sd7, 32'sh0001_0000);
    push_directed(CMD_CLEAR,  32'sd0, 32'sd0);
    push_directed(CMD_REMOVE, 32'sd0, 32'sd0);
    push_directed(CMD_INSERT, 32'sd9, -32'sh0000_8000);
    push_directed(CMD_REMOVE, 32'sd0, 32'sd0);
    push_directed(CMD_CLEAR,  32'sd0, 32'sd0);

    // Random phases: free flow, idle sender, stalling receiver, both.
    run_phase(0, 0, 40);
    repeat (2) begin
      run_phase(0, 0, PHASE_ITEMS);
      run_phase(70, 0, PHASE_ITEMS);
      run_phase(0, 70, PHASE_ITEMS);
      run_phase(27, 27, PHASE_ITEMS);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d predicted results never arrived", expected_results.size());
      fails++;
    end
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
